// ----- rtl/core/sitda_pkg.sv -----
package sitda_pkg;

    localparam int MAX_DIGITS  = 10;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
    localparam int POW_W       = 34;
    localparam int CHAR_W      = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    typedef enum logic {
        ST_IDLE,
        ST_DIGIT
    } t_back_state;

    // Returns k times ten to the power idx.
    function automatic logic [POW_W-1:0] pow10_mul(
        input logic [DIGIT_IDX_W-1:0] idx,
        input logic [3:0]             k
    );
        logic [POW_W-1:0] p;
        case (idx)
            4'd0:    p = 34'd1;
            4'd1:    p = 34'd10;
            4'd2:    p = 34'd100;
            4'd3:    p = 34'd1000;
            4'd4:    p = 34'd10000;
            4'd5:    p = 34'd100000;
            4'd6:    p = 34'd1000000;
            4'd7:    p = 34'd10000000;
            4'd8:    p = 34'd100000000;
            4'd9:    p = 34'd1000000000;
            default: p = 34'd0;
        endcase
        return POW_W'(p * POW_W'(k));
    endfunction

endpackage

// ----- rtl/core/sitda_front.sv -----
module sitda_front
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [31:0]                        i_value,
    output logic                               o_push,
    input  logic                               i_push_ready,
    output logic [VALUE_WIDTH+DIGIT_IDX_W:0]   o_item
);

    logic                        r_valid;
    logic                        r_neg;
    logic [VALUE_WIDTH-1:0]      r_mag;
    logic [VALUE_WIDTH-1:0]      raw;
    logic [DIGIT_IDX_W-1:0]      ndig;
    logic                        accept;

    assign raw     = i_value[VALUE_WIDTH-1:0];
    assign o_push  = r_valid;
    assign o_ready = !r_valid || i_push_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (accept) begin
            r_neg <= raw[VALUE_WIDTH-1];
            r_mag <= raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
        end
    end

    // The digit count is one plus the number of powers of ten from ten upward that are at or below the magnitude.
    always_comb begin
        ndig = DIGIT_IDX_W'(1);
        for (int i = 1; i < MAX_DIGITS; i++) begin
            if (POW_W'(r_mag) >= pow10_mul(DIGIT_IDX_W'(i), 4'd1)) begin
                ndig = ndig + 1'b1;
            end
        end
    end

    assign o_item = {r_neg, ndig, r_mag};

endmodule

// ----- rtl/core/sitda_fifo.sv -----
module sitda_fifo #(
    parameter int DATA_W = 37
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_push_ready,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);

    logic [1:0]        r_count;
    logic [DATA_W-1:0] r_data0;
    logic [DATA_W-1:0] r_data1;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_data       = r_data0;
    assign push         = i_push && o_push_ready;
    assign pop          = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (push && !pop) begin
            r_count <= r_count + 2'd1;
        end else if (pop && !push) begin
            r_count <= r_count - 2'd1;
        end
        if (push && !pop) begin
            if (r_count == 2'd0) begin
                r_data0 <= i_data;
            end else begin
                r_data1 <= i_data;
            end
        end else if (pop && !push) begin
            r_data0 <= r_data1;
        end else if (push && pop) begin
            if (r_count == 2'd1) begin
                r_data0 <= i_data;
            end else begin
                r_data0 <= r_data1;
                r_data1 <= i_data;
            end
        end
    end

endmodule

// ----- rtl/core/sitda_back.sv -----
module sitda_back
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_pop,
    input  logic [VALUE_WIDTH+DIGIT_IDX_W:0] i_item,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [CHAR_W-1:0]                o_char,
    output logic                             o_last
);

    t_back_state                 r_state;
    t_back_state                 n_state;
    logic [VALUE_WIDTH-1:0]      r_rem;
    logic [VALUE_WIDTH-1:0]      n_rem;
    logic [DIGIT_IDX_W-1:0]      r_idx;
    logic [DIGIT_IDX_W-1:0]      n_idx;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [CHAR_W-1:0]           r_char;
    logic [CHAR_W-1:0]           n_char;
    logic                        r_last;
    logic                        n_last;
    logic                        can_emit;
    logic [3:0]                  digit;
    logic [POW_W-1:0]            sub;
    logic                        item_neg;
    logic [DIGIT_IDX_W-1:0]      item_ndig;
    logic [VALUE_WIDTH-1:0]      item_mag;

    assign item_neg  = i_item[VALUE_WIDTH+DIGIT_IDX_W];
    assign item_ndig = i_item[VALUE_WIDTH+DIGIT_IDX_W-1:VALUE_WIDTH];
    assign item_mag  = i_item[VALUE_WIDTH-1:0];
    assign can_emit  = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    // The digit at the current power is the largest multiple that still fits.
    always_comb begin
        digit = 4'd0;
        sub   = '0;
        for (int k = 1; k < 10; k++) begin
            if (POW_W'(r_rem) >= pow10_mul(r_idx, 4'(k))) begin
                digit = 4'(k);
                sub   = pow10_mul(r_idx, 4'(k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_rem  <= n_rem;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && can_emit) begin
                    o_pop   = 1'b1;
                    n_rem   = item_mag;
                    n_idx   = item_ndig - 1'b1;
                    n_state = ST_DIGIT;
                    if (item_neg) begin
                        n_out_valid = 1'b1;
                        n_char      = ASCII_MINUS;
                        n_last      = 1'b0;
                    end
                end
            end
            ST_DIGIT: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    n_char      = ASCII_ZERO + CHAR_W'(digit);
                    n_last      = (r_idx == '0);
                    n_rem       = VALUE_WIDTH'(POW_W'(r_rem) - sub);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Prints a signed two's complement integer as decimal ASCII text. Each number taken on the
// input stream comes out as one transfer per character, most significant digit first, with a
// leading '-' for negative values, a single '0' for zero and tlast on the final character; the
// most negative value prints in full. The digit sequencer in the back end loads a number, then
// finds one digit a cycle while the output accepts, against a table of powers of ten, and takes
// no new number until its last digit is out. A front stage takes in numbers, forms the
// magnitude and counts its digits while a two-entry queue lets it run ahead.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // character in the low bits, with a zero pad bit on top
    output logic        o_m_axis_tlast
);

    localparam int ITEM_W = VALUE_WIDTH + DIGIT_IDX_W + 1;

    logic              push;
    logic              push_ready;
    logic [ITEM_W-1:0] push_item;
    logic              q_valid;
    logic              pop;
    logic [ITEM_W-1:0] q_item;
    logic [CHAR_W-1:0] out_char;

    sitda_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_value     (i_s_axis_tdata),
        .o_push      (push),
        .i_push_ready(push_ready),
        .o_item      (push_item)
    );

    sitda_fifo #(
        .DATA_W(ITEM_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_push_ready(push_ready),
        .i_data      (push_item),
        .o_valid     (q_valid),
        .i_pop       (pop),
        .o_data      (q_item)
    );

    sitda_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_pop  (pop),
        .i_item (q_item),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_char (out_char),
        .o_last (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_char};

endmodule
